>>> hdl/rfr_pkg.sv
package rfr_pkg;

  // default frame layout
  localparam int PAYLOAD_BYTES_DEF = 7;
  localparam int ID_BYTES_DEF      = 3;
  localparam int HEADER_BYTES_DEF  = 10;

  // fixed header positions
  localparam int POS_HDR0  = 0;
  localparam int POS_HDR1  = 1;
  localparam int POS_CMD   = 2;
  localparam int POS_INDEX = 3;
  localparam int POS_ID    = 4;

  localparam logic [7:0] HDR_BYTE0    = 8'h55;
  localparam logic [7:0] HDR_BYTE1    = 8'hAA;
  localparam logic [7:0] CMD_PAIR     = 8'h0A;
  localparam logic [7:0] CMD_NORMAL   = 8'h0F;
  localparam logic [7:0] RESERVED_MAX = 8'd10;
  localparam logic [7:0] INDEX_RESET  = 8'd100;

  // bytes carried by the id load port
  localparam int ID_PORT_BYTES = 3;

  // frame jobs waiting between front and back
  localparam int JOB_DEPTH = 2;

  typedef enum logic [1:0] {
    FUNC_BYTE    = 2'd0,
    FUNC_PAIR    = 2'd1,
    FUNC_LOAD_ID = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_STATUS  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ID      = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    V_SHORT       = 4'd0,
    V_BAD_HEADER  = 4'd1,
    V_BAD_SUM     = 4'd2,
    V_REPEAT      = 4'd3,
    V_FORWARDED   = 4'd4,
    V_MISMATCH    = 4'd5,
    V_PAIRED      = 4'd6,
    V_NOT_PAIRING = 4'd7,
    V_RESERVED    = 4'd8
  } verdict_t;

  typedef enum logic [1:0] {
    PH_ID     = 2'd0,
    PH_PAY    = 2'd1,
    PH_STATUS = 2'd2
  } phase_t;

  typedef struct packed {
    verdict_t    verdict;
    logic        accepted;
    logic [15:0] total;
    logic        emit_id;
    logic        emit_pay;
  } job_ctrl_t;

endpackage

>>> hdl/remote_frame_receiver_top.sv
// radio frame receiver
// input channel: push/full carries one item per transfer: a frame byte with its
// last_byte mark (func 0), enter pairing mode (func 1) or load a saved paired id
// (func 2). a frame is header, payload and an additive checksum byte.
// result channel: empty/pop presents the oldest result; each frame end gives an
// optional run of id bytes to save, an optional run of payload bytes to forward,
// then one status item with last set, carrying the verdict and running count.
// the transfer of a frame's final byte writes its job into the job queue; its first
// result is loaded into the output register once that register is free.
// throughput: one input byte per cycle while full is low; results leave at one
// per cycle while the receiver pops; a frame gives between 1 and id+payload+1
// results. the front judges each frame and parks it in a two-entry job queue;
// full rises while that queue holds two frames not yet drained.
// a stalled receiver holds the current result steady, the front keeps taking
// bytes until the job queue fills.
// reset: synchronous, clears the frame state, the job queue and the output
// register; the paired id reads as zero and pairing mode is off.
module remote_frame_receiver_top #(
  parameter int PAYLOAD_BYTES = rfr_pkg::PAYLOAD_BYTES_DEF,
  parameter int ID_BYTES      = rfr_pkg::ID_BYTES_DEF,
  parameter int HEADER_BYTES  = rfr_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  func,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [23:0] id_value,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [7:0]  out_byte,
  output logic [3:0]  verdict,
  output logic        accepted,
  output logic [15:0] accepted_total,
  output logic        last
);

  localparam int CW = $bits(rfr_pkg::job_ctrl_t);
  localparam int IDW = ID_BYTES * 8;
  localparam int PYW = PAYLOAD_BYTES * 8;
  localparam int JW = CW + IDW + PYW;

  logic                job_push;
  rfr_pkg::job_ctrl_t  job_ctrl;
  logic [IDW-1:0]      job_id;
  logic [PYW-1:0]      job_pay;
  logic [JW-1:0]       head_data;
  logic                head_valid;
  logic                head_pop;
  logic                take;
  rfr_pkg::job_ctrl_t  head_ctrl;

  assign take      = push && !full;
  assign head_ctrl = rfr_pkg::job_ctrl_t'(head_data[JW-1 -: CW]);

  rfr_front #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .ID_BYTES      (ID_BYTES),
    .HEADER_BYTES  (HEADER_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .func      (func),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .id_value  (id_value),
    .job_push  (job_push),
    .job_ctrl  (job_ctrl),
    .job_id    (job_id),
    .job_pay   (job_pay)
  );

  rfr_fifo #(
    .WIDTH (JW),
    .DEPTH (rfr_pkg::JOB_DEPTH)
  ) u_jobs (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (job_push),
    .wr_data   ({job_ctrl, job_id, job_pay}),
    .rd_en     (head_pop),
    .rd_data   (head_data),
    .not_empty (head_valid),
    .is_full   (full)
  );

  rfr_back #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .ID_BYTES      (ID_BYTES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_ctrl      (head_ctrl),
    .head_id        (head_data[PYW +: IDW]),
    .head_pay       (head_data[PYW-1:0]),
    .head_pop       (head_pop),
    .pop            (pop),
    .empty          (empty),
    .kind           (kind),
    .out_byte       (out_byte),
    .verdict        (verdict),
    .accepted       (accepted),
    .accepted_total (accepted_total),
    .last           (last)
  );

endmodule

>>> hdl/rfr_fifo.sv
module rfr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rfr_pkg::JOB_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             not_empty,
  output logic             is_full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign rd_data   = mem[rd_ptr];
  assign not_empty = (count != '0);
  assign is_full   = (count == CNT_FULL);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/rfr_front.sv
module rfr_front #(
  parameter int PAYLOAD_BYTES = rfr_pkg::PAYLOAD_BYTES_DEF,
  parameter int ID_BYTES      = rfr_pkg::ID_BYTES_DEF,
  parameter int HEADER_BYTES  = rfr_pkg::HEADER_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       take,
  input  logic [1:0]                 func,
  input  logic [7:0]                 data_byte,
  input  logic                       last_byte,
  input  logic [23:0]                id_value,
  output logic                       job_push,
  output rfr_pkg::job_ctrl_t         job_ctrl,
  output logic [ID_BYTES*8-1:0]      job_id,
  output logic [PAYLOAD_BYTES*8-1:0] job_pay
);

  localparam int FRAME_LEN = HEADER_BYTES + PAYLOAD_BYTES + 1;
  localparam int POSW      = $clog2(FRAME_LEN + 1);
  localparam logic [POSW-1:0] POS_END   = POSW'(FRAME_LEN);
  localparam logic [POSW-1:0] POS_SUM   = POSW'(FRAME_LEN - 1);
  localparam logic [POSW-1:0] POS_H0    = POSW'(rfr_pkg::POS_HDR0);
  localparam logic [POSW-1:0] POS_H1    = POSW'(rfr_pkg::POS_HDR1);
  localparam logic [POSW-1:0] POS_C     = POSW'(rfr_pkg::POS_CMD);
  localparam logic [POSW-1:0] POS_N     = POSW'(rfr_pkg::POS_INDEX);

  // frame being received
  logic [POSW-1:0] pos;
  logic [7:0]      run_sum;
  logic            hdr_ok;
  logic [7:0]      cmd;
  logic [7:0]      num;
  logic [7:0]      sumb;
  logic [7:0]      rid [ID_BYTES];
  logic [7:0]      pay [PAYLOAD_BYTES];

  // state across frames
  logic [7:0]      prev_idx;
  logic [7:0]      pid [ID_BYTES];
  logic            pairing;
  logic [15:0]     acc_count;

  // frame state with the current byte folded in
  logic [POSW-1:0] pos_next;
  logic [7:0]      run_sum_next;
  logic            hdr_ok_next;
  logic [7:0]      cmd_next;
  logic [7:0]      num_next;
  logic [7:0]      sumb_next;
  logic [7:0]      rid_next [ID_BYTES];
  logic [7:0]      pay_next [PAYLOAD_BYTES];

  logic [7:0]      ld_id [ID_BYTES];
  logic            id_rsvd;
  logic            id_match;
  logic            frame_pass;
  logic            pid_take;
  logic            pairing_clear;
  logic            count_inc;
  logic            byte_take;
  logic            frame_end;

  assign byte_take = take && (rfr_pkg::func_t'(func) == rfr_pkg::FUNC_BYTE);
  assign frame_end = byte_take && last_byte;
  assign job_push  = frame_end;

  for (genvar i = 0; i < ID_BYTES; i++) begin : g_id
    if (i < rfr_pkg::ID_PORT_BYTES) begin : g_port
      assign ld_id[i] = id_value[8*i +: 8];
    end else begin : g_zero
      assign ld_id[i] = '0;
    end
    assign job_id[8*i +: 8] = rid_next[i];
  end

  for (genvar i = 0; i < PAYLOAD_BYTES; i++) begin : g_pay
    assign job_pay[8*i +: 8] = pay_next[i];
  end

  always_comb begin
    pos_next     = pos;
    run_sum_next = run_sum;
    hdr_ok_next  = hdr_ok;
    cmd_next     = cmd;
    num_next     = num;
    sumb_next    = sumb;
    rid_next     = rid;
    pay_next     = pay;
    // bytes beyond a full frame are dropped
    if (pos != POS_END) begin
      if (pos == POS_H0 && data_byte != rfr_pkg::HDR_BYTE0) begin
        hdr_ok_next = 1'b0;
      end
      if (pos == POS_H1 && data_byte != rfr_pkg::HDR_BYTE1) begin
        hdr_ok_next = 1'b0;
      end
      if (pos == POS_C) begin
        cmd_next = data_byte;
      end
      if (pos == POS_N) begin
        num_next = data_byte;
      end
      for (int i = 0; i < ID_BYTES; i++) begin
        if (pos == POSW'(rfr_pkg::POS_ID + i)) begin
          rid_next[i] = data_byte;
        end
      end
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
        if (pos == POSW'(HEADER_BYTES + i)) begin
          pay_next[i] = data_byte;
        end
      end
      if (pos == POS_SUM) begin
        sumb_next = data_byte;
      end else begin
        run_sum_next = run_sum + data_byte;
      end
      pos_next = pos + 1'b1;
    end
  end

  always_comb begin
    id_rsvd  = (rid_next[0] <= rfr_pkg::RESERVED_MAX);
    id_match = 1'b1;
    for (int i = 0; i < ID_BYTES; i++) begin
      if (i > 0 && rid_next[i] != 8'd0) begin
        id_rsvd = 1'b0;
      end
      if (pid[i] != rid_next[i]) begin
        id_match = 1'b0;
      end
    end
  end

  always_comb begin
    job_ctrl          = '0;
    job_ctrl.verdict  = rfr_pkg::V_SHORT;
    job_ctrl.total    = acc_count;
    frame_pass        = 1'b0;
    pid_take          = 1'b0;
    pairing_clear     = 1'b0;
    count_inc         = 1'b0;
    if (pos_next != POS_END) begin
      job_ctrl.verdict = rfr_pkg::V_SHORT;
    end else if (!hdr_ok_next ||
                 (cmd_next != rfr_pkg::CMD_PAIR && cmd_next != rfr_pkg::CMD_NORMAL)) begin
      job_ctrl.verdict = rfr_pkg::V_BAD_HEADER;
    end else if (sumb_next != run_sum_next) begin
      job_ctrl.verdict = rfr_pkg::V_BAD_SUM;
    end else if (num_next == prev_idx) begin
      job_ctrl.verdict = rfr_pkg::V_REPEAT;
    end else begin
      frame_pass = 1'b1;
      if (cmd_next == rfr_pkg::CMD_PAIR) begin
        if (!pairing) begin
          job_ctrl.verdict = rfr_pkg::V_NOT_PAIRING;
        end else begin
          // a reserved id still overwrites the paired id
          pid_take = 1'b1;
          if (id_rsvd) begin
            job_ctrl.verdict = rfr_pkg::V_RESERVED;
          end else begin
            job_ctrl.verdict  = rfr_pkg::V_PAIRED;
            job_ctrl.emit_id  = 1'b1;
            job_ctrl.emit_pay = 1'b1;
            pairing_clear     = 1'b1;
          end
        end
      end else begin
        count_inc         = 1'b1;
        job_ctrl.accepted = 1'b1;
        job_ctrl.total    = acc_count + 16'd1;
        if (id_rsvd || id_match) begin
          job_ctrl.verdict  = rfr_pkg::V_FORWARDED;
          job_ctrl.emit_pay = 1'b1;
        end else begin
          job_ctrl.verdict = rfr_pkg::V_MISMATCH;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take) begin
      rid <= rid_next;
      pay <= pay_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      run_sum   <= '0;
      hdr_ok    <= 1'b1;
      cmd       <= '0;
      num       <= '0;
      sumb      <= '0;
      prev_idx  <= rfr_pkg::INDEX_RESET;
      pid       <= '{default: '0};
      pairing   <= 1'b0;
      acc_count <= '0;
    end else if (take) begin
      case (rfr_pkg::func_t'(func))
        rfr_pkg::FUNC_PAIR: begin
          pairing <= 1'b1;
        end
        rfr_pkg::FUNC_LOAD_ID: begin
          pid <= ld_id;
        end
        rfr_pkg::FUNC_BYTE: begin
          if (last_byte) begin
            pos     <= '0;
            run_sum <= '0;
            hdr_ok  <= 1'b1;
            cmd     <= '0;
            num     <= '0;
            sumb    <= '0;
            if (frame_pass) begin
              prev_idx <= num_next;
            end
            if (pid_take) begin
              pid <= rid_next;
            end
            if (pairing_clear) begin
              pairing <= 1'b0;
            end
            if (count_inc) begin
              acc_count <= acc_count + 16'd1;
            end
          end else begin
            pos     <= pos_next;
            run_sum <= run_sum_next;
            hdr_ok  <= hdr_ok_next;
            cmd     <= cmd_next;
            num     <= num_next;
            sumb    <= sumb_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hdl/rfr_back.sv
module rfr_back #(
  parameter int PAYLOAD_BYTES = rfr_pkg::PAYLOAD_BYTES_DEF,
  parameter int ID_BYTES      = rfr_pkg::ID_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  rfr_pkg::job_ctrl_t         head_ctrl,
  input  logic [ID_BYTES*8-1:0]      head_id,
  input  logic [PAYLOAD_BYTES*8-1:0] head_pay,
  output logic                       head_pop,
  input  logic                       pop,
  output logic                       empty,
  output logic [1:0]                 kind,
  output logic [7:0]                 out_byte,
  output logic [3:0]                 verdict,
  output logic                       accepted,
  output logic [15:0]                accepted_total,
  output logic                       last
);

  localparam int IW = (ID_BYTES > 1) ? $clog2(ID_BYTES) : 1;
  localparam int PW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [IW-1:0] ID_LAST  = IW'(ID_BYTES - 1);
  localparam logic [PW-1:0] PAY_LAST = PW'(PAYLOAD_BYTES - 1);

  rfr_pkg::phase_t state;
  rfr_pkg::phase_t state_next;
  rfr_pkg::phase_t eff;
  logic [IW-1:0]   id_idx;
  logic [IW-1:0]   id_idx_next;
  logic [PW-1:0]   pay_idx;
  logic [PW-1:0]   pay_idx_next;

  logic [7:0]      id_b  [ID_BYTES];
  logic [7:0]      pay_b [PAYLOAD_BYTES];

  logic            load;
  logic            out_valid;
  rfr_pkg::kind_t  res_kind;
  logic [7:0]      res_byte;
  logic            res_last;

  for (genvar i = 0; i < ID_BYTES; i++) begin : g_id
    assign id_b[i] = head_id[8*i +: 8];
  end
  for (genvar i = 0; i < PAYLOAD_BYTES; i++) begin : g_pay
    assign pay_b[i] = head_pay[8*i +: 8];
  end

  assign load  = head_valid && (!out_valid || pop);
  assign empty = !out_valid;

  // skip the parts of the job that emit nothing
  always_comb begin
    eff = state;
    if (eff == rfr_pkg::PH_ID && !head_ctrl.emit_id) begin
      eff = rfr_pkg::PH_PAY;
    end
    if (eff == rfr_pkg::PH_PAY && !head_ctrl.emit_pay) begin
      eff = rfr_pkg::PH_STATUS;
    end
  end

  always_comb begin
    state_next   = state;
    id_idx_next  = id_idx;
    pay_idx_next = pay_idx;
    if (load) begin
      case (eff)
        rfr_pkg::PH_ID: begin
          if (id_idx == ID_LAST) begin
            id_idx_next = '0;
            state_next  = rfr_pkg::PH_PAY;
          end else begin
            id_idx_next = id_idx + 1'b1;
          end
        end
        rfr_pkg::PH_PAY: begin
          if (pay_idx == PAY_LAST) begin
            pay_idx_next = '0;
            state_next   = rfr_pkg::PH_STATUS;
          end else begin
            pay_idx_next = pay_idx + 1'b1;
          end
        end
        rfr_pkg::PH_STATUS: begin
          state_next = rfr_pkg::PH_ID;
        end
        default: begin
          state_next = rfr_pkg::PH_ID;
        end
      endcase
    end
  end

  always_comb begin
    res_kind = rfr_pkg::KIND_STATUS;
    res_byte = '0;
    res_last = 1'b0;
    head_pop = 1'b0;
    case (eff)
      rfr_pkg::PH_ID: begin
        res_kind = rfr_pkg::KIND_ID;
        res_byte = id_b[id_idx];
      end
      rfr_pkg::PH_PAY: begin
        res_kind = rfr_pkg::KIND_PAYLOAD;
        res_byte = pay_b[pay_idx];
      end
      rfr_pkg::PH_STATUS: begin
        res_last = 1'b1;
        head_pop = load;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rfr_pkg::PH_ID;
      id_idx    <= '0;
      pay_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      id_idx  <= id_idx_next;
      pay_idx <= pay_idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind           <= res_kind;
      out_byte       <= res_byte;
      verdict        <= head_ctrl.verdict;
      accepted       <= head_ctrl.accepted;
      accepted_total <= head_ctrl.total;
      last           <= res_last;
    end
  end

endmodule

>>> tb/remote_frame_receiver_top_tb.sv
module remote_frame_receiver_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ID_N         = rfr_pkg::ID_BYTES_DEF;
  localparam int PAY_N        = rfr_pkg::PAYLOAD_BYTES_DEF;
  localparam int HDR_N        = rfr_pkg::HEADER_BYTES_DEF;
  localparam int FRAME_LEN    = HDR_N + PAY_N + 1;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    rfr_pkg::func_t f;
    logic [7:0]     data;
    logic           lb;
    logic [23:0]    idv;
  } radio_item_t;

  typedef struct {
    rfr_pkg::kind_t    kind;
    logic [7:0]        data;
    rfr_pkg::verdict_t verdict;
    logic              acc;
    logic [15:0]       total;
    logic              last;
  } frame_result_t;

  typedef enum int {
    SC_MATCH, SC_RESERVED_ID, SC_FOREIGN_ID, SC_PAIR, SC_PAIR_RESERVED, SC_PAIR_UNARMED,
    SC_REPEAT, SC_SHORT, SC_LONG, SC_BAD_HDR, SC_BAD_CMD, SC_BAD_SUM
  } scenario_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  func = rfr_pkg::FUNC_NONE;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic [23:0] id_value = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [3:0]  verdict;
  logic        accepted;
  logic [15:0] accepted_total;
  logic        last;

  remote_frame_receiver_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .func(func), .data_byte(data_byte),
    .last_byte(last_byte), .id_value(id_value), .empty(empty), .pop(pop), .kind(kind),
    .out_byte(out_byte), .verdict(verdict), .accepted(accepted),
    .accepted_total(accepted_total), .last(last)
  );

  // receiver state as the predictor sees it
  int                    rx_pos = 0;
  logic [7:0]            rx_sum = '0;
  logic [7:0]            rx_cmd = '0;
  logic [7:0]            rx_index = '0;
  logic [7:0]            rx_check = '0;
  logic                  rx_hdr_ok = 1'b1;
  logic [ID_N-1:0][7:0]  rx_id = '0;
  logic [PAY_N-1:0][7:0] rx_payload = '0;
  logic [7:0]            last_index = rfr_pkg::INDEX_RESET;
  logic [ID_N-1:0][7:0]  paired_id = '0;
  logic                  pairing = 1'b0;
  logic [15:0]           accepted_count = '0;

  radio_item_t   radio_items[$];
  frame_result_t results_due[$];

  int items_queued = 0;
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_started = 0;
  int hold_left = 0;
  int cycle_count = 0;

  // what the stimulus side believes, only used to steer frame content
  logic [7:0]  gen_index = rfr_pkg::INDEX_RESET;
  logic [23:0] gen_paired = '0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic bit id_is_reserved(logic [ID_N-1:0][7:0] id);
    return id[ID_N-1:1] == '0 && id[0] <= rfr_pkg::RESERVED_MAX;
  endfunction

  task automatic report_mismatch(string what);
    if (error_count < 200) $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  task automatic expect_result(rfr_pkg::kind_t k, logic [7:0] b, rfr_pkg::verdict_t v,
                               logic acc, logic fin);
    frame_result_t r;
    r.kind    = k;
    r.data    = b;
    r.verdict = v;
    r.acc     = acc;
    r.total   = accepted_count;
    r.last    = fin;
    results_due.push_back(r);
  endtask

  task automatic judge_frame();
    if (rx_pos < FRAME_LEN) begin
      expect_result(rfr_pkg::KIND_STATUS, 8'h00, rfr_pkg::V_SHORT, 1'b0, 1'b1);
    end else if (!rx_hdr_ok ||
                 (rx_cmd != rfr_pkg::CMD_PAIR && rx_cmd != rfr_pkg::CMD_NORMAL)) begin
      expect_result(rfr_pkg::KIND_STATUS, 8'h00, rfr_pkg::V_BAD_HEADER, 1'b0, 1'b1);
    end else if (rx_check != rx_sum) begin
      expect_result(rfr_pkg::KIND_STATUS, 8'h00, rfr_pkg::V_BAD_SUM, 1'b0, 1'b1);
    end else if (rx_index == last_index) begin
      expect_result(rfr_pkg::KIND_STATUS, 8'h00, rfr_pkg::V_REPEAT, 1'b0, 1'b1);
    end else begin
      last_index = rx_index;
      if (rx_cmd == rfr_pkg::CMD_PAIR) begin
        if (!pairing) begin
          expect_result(rfr_pkg::KIND_STATUS, 8'h00, rfr_pkg::V_NOT_PAIRING, 1'b0, 1'b1);
        end else begin
          // the id is taken even when it turns out to be reserved
          paired_id = rx_id;
          if (id_is_reserved(paired_id)) begin
            expect_result(rfr_pkg::KIND_STATUS, 8'h00, rfr_pkg::V_RESERVED, 1'b0, 1'b1);
          end else begin
            for (int i = 0; i < ID_N; i++)
              expect_result(rfr_pkg::KIND_ID, paired_id[i], rfr_pkg::V_PAIRED, 1'b0, 1'b0);
            for (int i = 0; i < PAY_N; i++)
              expect_result(rfr_pkg::KIND_PAYLOAD, rx_payload[i], rfr_pkg::V_PAIRED,
                            1'b0, 1'b0);
            pairing = 1'b0;
            expect_result(rfr_pkg::KIND_STATUS, 8'h00, rfr_pkg::V_PAIRED, 1'b0, 1'b1);
          end
        end
      end else begin
        accepted_count++;
        if (id_is_reserved(rx_id) || rx_id == paired_id) begin
          for (int i = 0; i < PAY_N; i++)
            expect_result(rfr_pkg::KIND_PAYLOAD, rx_payload[i], rfr_pkg::V_FORWARDED,
                          1'b1, 1'b0);
          expect_result(rfr_pkg::KIND_STATUS, 8'h00, rfr_pkg::V_FORWARDED, 1'b1, 1'b1);
        end else begin
          expect_result(rfr_pkg::KIND_STATUS, 8'h00, rfr_pkg::V_MISMATCH, 1'b1, 1'b1);
        end
      end
    end
  endtask

  task automatic absorb_item(radio_item_t it);
    case (it.f)
      rfr_pkg::FUNC_PAIR:    pairing = 1'b1;
      rfr_pkg::FUNC_LOAD_ID: paired_id = it.idv;
      rfr_pkg::FUNC_BYTE: begin
        // bytes past the frame length are dropped
        if (rx_pos < FRAME_LEN) begin
          if (rx_pos == rfr_pkg::POS_HDR0 && it.data != rfr_pkg::HDR_BYTE0) rx_hdr_ok = 1'b0;
          if (rx_pos == rfr_pkg::POS_HDR1 && it.data != rfr_pkg::HDR_BYTE1) rx_hdr_ok = 1'b0;
          if (rx_pos == rfr_pkg::POS_CMD) rx_cmd = it.data;
          if (rx_pos == rfr_pkg::POS_INDEX) rx_index = it.data;
          if (rx_pos >= rfr_pkg::POS_ID && rx_pos < rfr_pkg::POS_ID + ID_N)
            rx_id[rx_pos - rfr_pkg::POS_ID] = it.data;
          if (rx_pos >= HDR_N && rx_pos < HDR_N + PAY_N)
            rx_payload[rx_pos - HDR_N] = it.data;
          if (rx_pos == FRAME_LEN - 1) rx_check = it.data;
          else rx_sum += it.data;
          rx_pos++;
        end
        if (it.lb) begin
          judge_frame();
          rx_pos    = 0;
          rx_sum    = '0;
          rx_hdr_ok = 1'b1;
          rx_cmd    = '0;
          rx_index  = '0;
          rx_check  = '0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic queue_item(rfr_pkg::func_t f, logic [7:0] b, logic lb, logic [23:0] idv);
    radio_item_t it;
    it.f    = f;
    it.data = b;
    it.lb   = lb;
    it.idv  = idv;
    radio_items.push_back(it);
    items_queued++;
  endtask

  task automatic add_frame(logic [7:0] cmd, logic [7:0] idx, logic [23:0] id, scenario_t sc);
    logic [7:0] bytes[$];
    logic [7:0] check;
    int         cut;
    int         stray_at;
    bytes = {};
    bytes.push_back(rfr_pkg::HDR_BYTE0);
    bytes.push_back(rfr_pkg::HDR_BYTE1);
    bytes.push_back(cmd);
    bytes.push_back(idx);
    for (int i = 0; i < ID_N; i++) bytes.push_back(id[8*i +: 8]);
    while (bytes.size() < FRAME_LEN - 1) bytes.push_back(8'($urandom_range(255)));
    check = '0;
    foreach (bytes[i]) check += bytes[i];
    bytes.push_back(check);
    case (sc)
      SC_SHORT: begin
        cut = $urandom_range(1, FRAME_LEN - 1);
        while (bytes.size() > cut) void'(bytes.pop_back());
      end
      SC_LONG:    repeat ($urandom_range(1, 4)) bytes.push_back(8'($urandom_range(255)));
      SC_BAD_HDR: bytes[$urandom_range(1)] ^= 8'($urandom_range(1, 255));
      SC_BAD_SUM: bytes[FRAME_LEN-1] += 8'($urandom_range(1, 255));
      default: ;
    endcase
    // now and then a control item lands in the middle of the frame
    stray_at = ($urandom_range(9) == 0) ? $urandom_range(bytes.size() - 1) : -1;
    foreach (bytes[i]) begin
      if (i == stray_at)
        queue_item(rfr_pkg::func_t'($urandom_range(1, 3)), 8'($urandom_range(255)),
                   1'($urandom_range(1)), gen_paired);
      queue_item(rfr_pkg::FUNC_BYTE, bytes[i], i == bytes.size() - 1, 24'($urandom));
    end
  endtask

  task automatic add_scenario(scenario_t sc);
    logic [7:0]  idx;
    logic [7:0]  cmd;
    logic [23:0] id;
    idx = 8'($urandom_range(255));
    if (idx == gen_index) idx++;
    if (sc == SC_REPEAT) idx = gen_index;
    cmd = rfr_pkg::CMD_NORMAL;
    id  = gen_paired;
    case (sc)
      SC_RESERVED_ID: id = 24'($urandom_range(rfr_pkg::RESERVED_MAX));
      SC_FOREIGN_ID:  id = 24'($urandom);
      SC_PAIR: begin
        queue_item(rfr_pkg::FUNC_PAIR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                   24'($urandom));
        cmd = rfr_pkg::CMD_PAIR;
        id  = 24'($urandom);
        if (id <= rfr_pkg::RESERVED_MAX) id[8] = 1'b1;
        gen_paired = id;
      end
      SC_PAIR_RESERVED: begin
        queue_item(rfr_pkg::FUNC_PAIR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                   24'($urandom));
        cmd = rfr_pkg::CMD_PAIR;
        id  = 24'($urandom_range(rfr_pkg::RESERVED_MAX));
        gen_paired = id;
      end
      SC_PAIR_UNARMED: begin
        cmd = rfr_pkg::CMD_PAIR;
        id  = 24'($urandom);
      end
      SC_BAD_CMD: begin
        do cmd = 8'($urandom_range(255));
        while (cmd == rfr_pkg::CMD_PAIR || cmd == rfr_pkg::CMD_NORMAL);
      end
      default: ;
    endcase
    if (sc inside {SC_MATCH, SC_RESERVED_ID, SC_FOREIGN_ID, SC_PAIR, SC_PAIR_RESERVED,
                   SC_PAIR_UNARMED, SC_LONG})
      gen_index = idx;
    add_frame(cmd, idx, id, sc);
  endtask

  function automatic scenario_t pick_scenario();
    int r;
    r = $urandom_range(99);
    if (r < 35) return SC_MATCH;
    if (r < 45) return SC_RESERVED_ID;
    if (r < 53) return SC_FOREIGN_ID;
    if (r < 65) return SC_PAIR;
    if (r < 68) return SC_PAIR_RESERVED;
    if (r < 71) return SC_PAIR_UNARMED;
    if (r < 76) return SC_REPEAT;
    if (r < 82) return SC_SHORT;
    if (r < 87) return SC_LONG;
    if (r < 91) return SC_BAD_HDR;
    if (r < 95) return SC_BAD_CMD;
    return SC_BAD_SUM;
  endfunction

  task automatic add_random_items(int count);
    int target;
    int r;
    target = items_queued + count;
    while (items_queued < target) begin
      r = $urandom_range(99);
      if (r < 5) begin
        if ($urandom_range(1)) gen_paired = 24'($urandom);
        queue_item(rfr_pkg::FUNC_LOAD_ID, 8'($urandom_range(255)), 1'($urandom_range(1)),
                   gen_paired);
      end else if (r < 8) begin
        queue_item(rfr_pkg::FUNC_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                   24'($urandom));
      end else begin
        add_scenario(pick_scenario());
      end
    end
  endtask

  task automatic wait_drained();
    while (radio_items.size() != 0 || results_due.size() != 0) @(negedge clk);
  endtask

  task automatic check_result();
    frame_result_t want;
    if (results_due.size() == 0) begin
      report_mismatch($sformatf("result with none due: kind %0d byte %02h verdict %0d",
                                kind, out_byte, verdict));
      return;
    end
    want = results_due.pop_front();
    if (kind != want.kind)
      report_mismatch($sformatf("kind got %0d want %0d", kind, want.kind));
    if (out_byte != want.data)
      report_mismatch($sformatf("out_byte got %02h want %02h", out_byte, want.data));
    if (verdict != want.verdict)
      report_mismatch($sformatf("verdict got %0d want %0d", verdict, want.verdict));
    if (accepted != want.acc)
      report_mismatch($sformatf("accepted got %0b want %0b", accepted, want.acc));
    if (accepted_total != want.total)
      report_mismatch($sformatf("accepted_total got %0d want %0d", accepted_total,
                                want.total));
    if (last != want.last)
      report_mismatch($sformatf("last got %0b want %0b", last, want.last));
  endtask

  // sender: one transfer per edge at most, front of the queue stays on the ports until taken
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) absorb_item(radio_items.pop_front());
      if (radio_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        push      <= 1'b1;
        func      <= radio_items[0].f;
        data_byte <= radio_items[0].data;
        last_byte <= radio_items[0].lb;
        id_value  <= radio_items[0].idv;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // long receiver hold-off, started on request
  always @(posedge clk) begin
    if (holds_started != hold_requests) begin
      holds_started <= hold_requests;
      hold_left     <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_result();
      pop <= hold_left == 0 && $urandom_range(99) >= recv_idle_pct;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    wait (!rst);
    @(negedge clk);
    send_idle_pct = 17;
    recv_idle_pct = 48;

    // field extremes, every function code and frames cut very short
    queue_item(rfr_pkg::FUNC_NONE, 8'hFF, 1'b1, 24'hFFFFFF);
    queue_item(rfr_pkg::FUNC_BYTE, 8'hFF, 1'b1, 24'h000000);
    queue_item(rfr_pkg::FUNC_BYTE, 8'h00, 1'b0, 24'hFFFFFF);
    queue_item(rfr_pkg::FUNC_BYTE, 8'h00, 1'b1, 24'h000000);
    queue_item(rfr_pkg::FUNC_LOAD_ID, 8'h00, 1'b1, 24'hFFFFFF);
    queue_item(rfr_pkg::FUNC_LOAD_ID, 8'hFF, 1'b0, 24'h000000);
    add_scenario(SC_PAIR);
    wait_drained();

    add_random_items(10);
    wait_drained();

    send_idle_pct = 48;
    recv_idle_pct = 17;
    add_random_items(20);
    wait_drained();

    // no idling; receiver holds off while good frames pile up behind full
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    repeat (3) add_scenario(SC_MATCH);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
